/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, types and bit helpers for the free-block bitmap.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int BLK_W      = 12;
  localparam int MAP_BYTES  = (MAX_BLOCKS + 7) / 8;
  localparam int ADDR_W     = $clog2(MAP_BYTES);
  localparam int LAST_BLOCK_RESET = 4095;

  localparam logic [7:0] BIT_TOP = 8'h80;

  typedef enum logic [1:0] {
    ACT_MARK_USED = 2'd0,
    ACT_MARK_FREE = 2'd1,
    ACT_ALLOCATE  = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN
  } state_t;

  function automatic logic [7:0] bit_of(input logic [2:0] idx);
    return BIT_TOP >> idx;
  endfunction

endpackage

/* rtl/core/bitmap_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator unit
// First-fit free-block bitmap, one bit per block, MSB-first in each byte,
// held in a single-port-write synchronous RAM of MAP_BYTES bytes.
// ----------------------------------------------------------------------------
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// request  | start, busy             | action, block_number
// result   | done (one-cycle strobe) | allocated_block, disk_full
// config   | cfg_valid, cfg_ready    | cfg_last_block
//
// Mark actions read the bitmap byte on accept and write it back from ST_MARK;
// the unused code gives its result straight from idle. Allocate reads one
// bitmap byte a cycle from byte 0 up to the byte that holds the last block.
// After reset a clearing pass writes every byte to zero, and busy stays high
// until it ends. Config writes are taken at any time.
// Results cannot be stalled; done is high for exactly one cycle per item.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic [bba_pkg::BLK_W-1:0] block_number,
  output logic                     done,
  output logic [bba_pkg::BLK_W-1:0] allocated_block,
  output logic                     disk_full,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [bba_pkg::BLK_W-1:0] cfg_last_block
);

  localparam int AW = bba_pkg::ADDR_W;
  localparam int BW = bba_pkg::BLK_W;

  logic [7:0] mem [bba_pkg::MAP_BYTES];
  logic [7:0] rd_data;

  bba_pkg::state_t  state, state_next;
  bba_pkg::action_t act, act_next;
  logic [BW-1:0] blk, blk_next;
  logic [BW-1:0] last_block;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] scan_addr, scan_addr_next;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;
  logic          res_load, res_full;
  logic [BW-1:0] res_block;

  logic [BW-1:0] top_blk;
  logic [AW-1:0] top_byte;
  logic          at_top, hit, blk_ok, clr_last;
  logic [2:0]    hit_idx;
  logic [7:0]    used_mask;

  assign cfg_ready = 1'b1;
  assign busy      = (state != bba_pkg::ST_IDLE);

  assign top_blk  = (32'(last_block) >= bba_pkg::MAX_BLOCKS) ?
                    BW'(bba_pkg::MAX_BLOCKS - 1) : last_block;
  assign top_byte = AW'(top_blk >> 3);
  assign at_top   = (scan_addr == top_byte);
  assign blk_ok   = (32'(blk) < bba_pkg::MAX_BLOCKS);
  assign clr_last = (clr_addr == AW'(bba_pkg::MAP_BYTES - 1));

  always_comb begin
    used_mask = rd_data;
    hit       = 1'b0;
    hit_idx   = '0;
    for (int i = 0; i < 8; i++) begin
      if (at_top && (3'(i) > top_blk[2:0])) begin
        used_mask = used_mask | bba_pkg::bit_of(3'(i));
      end
    end
    for (int i = 7; i >= 0; i--) begin
      if ((used_mask & bba_pkg::bit_of(3'(i))) == 8'h00) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        if (start) begin
          case (bba_pkg::action_t'(action))
            bba_pkg::ACT_MARK_USED, bba_pkg::ACT_MARK_FREE: state_next = bba_pkg::ST_MARK;
            bba_pkg::ACT_ALLOCATE:                          state_next = bba_pkg::ST_SCAN;
            default:                                        state_next = bba_pkg::ST_IDLE;
          endcase
        end
      end
      bba_pkg::ST_MARK: state_next = bba_pkg::ST_IDLE;
      bba_pkg::ST_SCAN: begin
        if (hit || at_top) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = scan_addr;
    mem_wdata      = rd_data;
    mem_re         = 1'b0;
    mem_raddr      = scan_addr;
    res_load       = 1'b0;
    res_block      = blk;
    res_full       = 1'b0;
    clr_addr_next  = clr_addr;
    scan_addr_next = scan_addr;
    act_next       = act;
    blk_next       = blk;
    case (state)
      bba_pkg::ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = 8'h00;
        clr_addr_next = clr_addr + AW'(1);
      end
      bba_pkg::ST_IDLE: begin
        if (start) begin
          act_next = bba_pkg::action_t'(action);
          blk_next = block_number;
          case (bba_pkg::action_t'(action))
            bba_pkg::ACT_MARK_USED, bba_pkg::ACT_MARK_FREE: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(block_number >> 3);
            end
            bba_pkg::ACT_ALLOCATE: begin
              mem_re         = 1'b1;
              mem_raddr      = '0;
              scan_addr_next = '0;
            end
            default: begin
              res_load  = 1'b1;
              res_block = block_number;
            end
          endcase
        end
      end
      bba_pkg::ST_MARK: begin
        res_load  = 1'b1;
        mem_waddr = AW'(blk >> 3);
        if (blk_ok) begin
          mem_we = 1'b1;
        end
        if (act == bba_pkg::ACT_MARK_USED) begin
          mem_wdata = rd_data | bba_pkg::bit_of(blk[2:0]);
        end else begin
          mem_wdata = rd_data & ~bba_pkg::bit_of(blk[2:0]);
        end
      end
      bba_pkg::ST_SCAN: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data | bba_pkg::bit_of(hit_idx);
          res_load  = 1'b1;
          res_block = BW'({scan_addr, hit_idx});
        end else if (at_top) begin
          res_load  = 1'b1;
          res_block = '0;
          res_full  = 1'b1;
        end else begin
          mem_re         = 1'b1;
          mem_raddr      = scan_addr + AW'(1);
          scan_addr_next = scan_addr + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bba_pkg::ST_CLEAR;
      clr_addr   <= '0;
      done       <= 1'b0;
      last_block <= BW'(bba_pkg::LAST_BLOCK_RESET);
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= res_load;
      if (cfg_valid && cfg_ready) begin
        last_block <= cfg_last_block;
      end
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    blk       <= blk_next;
    scan_addr <= scan_addr_next;
    if (res_load) begin
      allocated_block <= res_block;
      disk_full       <= res_full;
    end
  end

endmodule

/* rtl/core/bba_checker.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Port-level properties of the allocator, bound to the allocator unit.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                action,
  input logic                      done,
  input logic [bba_pkg::BLK_W-1:0] allocated_block,
  input logic                      disk_full,
  input logic                      cfg_ready
);

  // clearing pass holds the request side off
  a_clear_busy: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("busy low right after reset");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start || busy))
    else $error("result beat with no request behind it");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && disk_full) |-> (allocated_block == '0))
    else $error("disk full result with nonzero block");

  a_work_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == 2'(bba_pkg::ACT_MARK_USED) ||
     action == 2'(bba_pkg::ACT_MARK_FREE) || action == 2'(bba_pkg::ACT_ALLOCATE)))
    |=> busy)
    else $error("bitmap action did not hold busy");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .action          (action),
  .done            (done),
  .allocated_block (allocated_block),
  .disk_full       (disk_full),
  .cfg_ready       (cfg_ready)
);
